>>> rtl/core/lnr_pkg.sv
// Shared types and constants for the letterbox nearest-neighbour resizer.
// Used by the channel interfaces, datapath, controller and top level.
// No dependencies.
package lnr_pkg;

  // Default parameter values
  localparam int DEF_MAX_SOURCE_DIM = 2048;
  localparam int DEF_MAX_TARGET_DIM = 1024;

  // Field widths on the channels and registers
  localparam int PIXW  = 16;
  localparam int SRCRW = 12;
  localparam int TGTRW = 11;
  localparam int IDXW  = 20;
  localparam int CHW   = 8;
  localparam int FITW  = 11;
  localparam int OFSW  = 9;
  localparam int SQW   = 12;
  localparam int SQHW  = 10;

  // APB port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register reset values
  localparam logic [SRCRW-1:0] RST_SRC_W = SRCRW'(640);
  localparam logic [SRCRW-1:0] RST_SRC_H = SRCRW'(480);
  localparam logic [TGTRW-1:0] RST_TGT_W = TGTRW'(192);
  localparam logic [TGTRW-1:0] RST_TGT_H = TGTRW'(192);

  // Fixed point
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 1 << 15;

  // Channel offset to make signed int8
  localparam logic [CHW-1:0] RGB_BIAS = 8'h80;

  // Register map, indexed by paddr[3:2]
  typedef enum logic [1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_TGT_W = 2'd2,
    CFG_TGT_H = 2'd3
  } lnr_cfg_reg_t;

  // Divider job select
  typedef enum logic [1:0] {
    DIV_SCALE_W,
    DIV_SCALE_H,
    DIV_STEP_X,
    DIV_STEP_Y
  } lnr_div_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LATCH,
    ST_SCW_GO,
    ST_SCW_WAIT,
    ST_SCH_GO,
    ST_SCH_WAIT,
    ST_MUL_W,
    ST_FIT_W,
    ST_FIT_H,
    ST_PAD,
    ST_STX_GO,
    ST_STX_WAIT,
    ST_STY_GO,
    ST_STY_WAIT,
    ST_INIT,
    ST_PROC
  } lnr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic         step;       // run one pixel through the sampler
    logic         use_held;   // sampler takes the held frame-start pixel
    logic         hold_pix;   // capture the incoming pixel
    logic         latch_dims; // clamp and latch the frame dimensions
    logic         div_start;
    lnr_div_sel_t div_sel;
    logic         mul_w;      // product <= width * scale
    logic         fit_w;      // fitted width from product, product <= height * scale
    logic         fit_h;      // fitted height from product
    logic         set_pad;
    logic         init_frame; // clear counters, set row base
  } lnr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_stall;
  } lnr_sts_t;

endpackage

>>> rtl/core/lnr_if.sv
// Request channels of the resizer: source pixels in, sampled pixels out.
// Depends on lnr_pkg for field widths.
interface lnr_pix_if import lnr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PIXW-1:0] pixel_word;
  logic            frame_start;

  modport source(output valid, output pixel_word, output frame_start, input ready);
  modport sink(input valid, input pixel_word, input frame_start, output ready);
endinterface

interface lnr_res_if import lnr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IDXW-1:0]        dest_index;
  logic signed [CHW-1:0]  red_value;
  logic signed [CHW-1:0]  green_value;
  logic signed [CHW-1:0]  blue_value;
  logic                   frame_done;
  logic [FITW-1:0]        fitted_width;
  logic [FITW-1:0]        fitted_height;
  logic [OFSW-1:0]        offset_x;
  logic [OFSW-1:0]        offset_y;
  logic [SQW-1:0]         square_size;
  logic [SQHW-1:0]        square_pad_half;

  modport source(output valid, output dest_index, output red_value, output green_value,
                 output blue_value, output frame_done, output fitted_width,
                 output fitted_height, output offset_x, output offset_y,
                 output square_size, output square_pad_half, input ready);
  modport sink(input valid, input dest_index, input red_value, input green_value,
               input blue_value, input frame_done, input fitted_width,
               input fitted_height, input offset_x, input offset_y,
               input square_size, input square_pad_half, output ready);
endinterface

>>> rtl/core/lnr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module lnr_div #(
  parameter int DW = 28,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = (DW > 1) ? $clog2(DW) : 1;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;
  logic [VW-1:0]   dvs_r, dvs_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic [VW:0]     trial;

  // One shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = VW'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = VW'(trial);
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = CNTW'(cnt_r + 1'b1);
      if (cnt_r == CNTW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/lnr_datapath.sv
// Datapath of the resizer: frame setup arithmetic, sampling counters and
// the output register. Depends on lnr_pkg and lnr_div.
module lnr_datapath import lnr_pkg::*; #(
  parameter int MAX_SOURCE_DIM = DEF_MAX_SOURCE_DIM,
  parameter int MAX_TARGET_DIM = DEF_MAX_TARGET_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SRCRW-1:0]      cfg_src_w,
  input  logic [SRCRW-1:0]      cfg_src_h,
  input  logic [TGTRW-1:0]      cfg_tgt_w,
  input  logic [TGTRW-1:0]      cfg_tgt_h,
  input  logic [PIXW-1:0]       in_pixel,
  input  lnr_cmd_t              cmd,
  output lnr_sts_t              sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [IDXW-1:0]       out_dest_index,
  output logic signed [CHW-1:0] out_red,
  output logic signed [CHW-1:0] out_green,
  output logic signed [CHW-1:0] out_blue,
  output logic                  out_frame_done,
  output logic [FITW-1:0]       out_fit_w,
  output logic [FITW-1:0]       out_fit_h,
  output logic [OFSW-1:0]       out_ofs_x,
  output logic [OFSW-1:0]       out_ofs_y,
  output logic [SQW-1:0]        out_square,
  output logic [SQHW-1:0]       out_square_half
);

  localparam int SW  = $clog2(MAX_SOURCE_DIM + 1);
  localparam int TW  = $clog2(MAX_TARGET_DIM + 1);
  localparam int XW  = (SW > TW) ? SW : TW;
  localparam int DW  = SW + FRAC_BITS;
  localparam int SCW = FRAC_BITS + 1;
  localparam int PW  = SW + SCW;
  localparam int RW  = PW + 1 - FRAC_BITS;
  localparam int RBW = 2 * TW;

  // Frame constants
  logic [SW-1:0]   sw_r, sh_r, big_r;
  logic [SW-2:0]   half_r;
  logic [TW-1:0]   tw_r, th_r, fw_r, fh_r;
  logic [TW-2:0]   pad_x_r, pad_y_r;
  logic [SCW-1:0]  scw_r, sch_r;
  logic [DW-1:0]   step_x_r, step_y_r;
  logic [PW-1:0]   prod_r;
  logic [PIXW-1:0] held_px_r;

  // Sampling state
  logic            frame_valid_r, frame_valid_nxt;
  logic [SW-1:0]   src_col_r, src_col_nxt;
  logic [SW-1:0]   src_row_r, src_row_nxt;
  logic [TW-1:0]   dst_col_r, dst_col_nxt;
  logic [TW-1:0]   dst_row_r, dst_row_nxt;
  logic [DW-1:0]   acc_x_r, acc_x_nxt;
  logic [DW-1:0]   acc_y_r, acc_y_nxt;
  logic [RBW-1:0]  row_base_r, row_base_nxt;

  // Output register
  logic                  out_valid_r;
  logic [IDXW-1:0]       idx_r;
  logic [CHW-1:0]        red_r, green_r, blue_r;
  logic                  done_r;

  // Clamp of the configured dimensions
  logic [SW-1:0]   sw_c, sh_c;
  logic [TW-1:0]   tw_c, th_c, tw_f, th_f;

  always_comb begin
    if (cfg_src_w == '0) sw_c = SW'(1);
    else if (cfg_src_w > MAX_SOURCE_DIM) sw_c = SW'(MAX_SOURCE_DIM);
    else sw_c = SW'(cfg_src_w);
    if (cfg_src_h == '0) sh_c = SW'(1);
    else if (cfg_src_h > MAX_SOURCE_DIM) sh_c = SW'(MAX_SOURCE_DIM);
    else sh_c = SW'(cfg_src_h);
    if (cfg_tgt_w == '0) tw_c = TW'(1);
    else if (cfg_tgt_w > MAX_TARGET_DIM) tw_c = TW'(MAX_TARGET_DIM);
    else tw_c = TW'(cfg_tgt_w);
    if (cfg_tgt_h == '0) th_c = TW'(1);
    else if (cfg_tgt_h > MAX_TARGET_DIM) th_c = TW'(MAX_TARGET_DIM);
    else th_c = TW'(cfg_tgt_h);
    // only downscale
    tw_f = (XW'(tw_c) > XW'(sw_c)) ? TW'(sw_c) : tw_c;
    th_f = (XW'(th_c) > XW'(sh_c)) ? TW'(sh_c) : th_c;
  end

  // Shared divider
  logic [DW-1:0] div_a, div_q;
  logic [SW-1:0] div_b;
  logic          div_done;

  always_comb begin
    case (cmd.div_sel)
      DIV_SCALE_W: begin
        div_a = DW'(tw_r) << FRAC_BITS;
        div_b = sw_r;
      end
      DIV_SCALE_H: begin
        div_a = DW'(th_r) << FRAC_BITS;
        div_b = sh_r;
      end
      DIV_STEP_X: begin
        div_a = DW'(sw_r) << FRAC_BITS;
        div_b = SW'(fw_r);
      end
      DIV_STEP_Y: begin
        div_a = DW'(sh_r) << FRAC_BITS;
        div_b = SW'(fh_r);
      end
      default: begin
        div_a = '0;
        div_b = SW'(1);
      end
    endcase
  end

  lnr_div #(
    .DW(DW),
    .VW(SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Scale, fitted size rounding and clamp
  logic [SCW-1:0] scale;
  logic [SW-1:0]  mul_a;
  logic [PW:0]    rnd;
  logic [RW-1:0]  fit_raw;
  logic [TW-1:0]  fit_tgt, fit_val;

  always_comb begin
    scale   = (scw_r < sch_r) ? scw_r : sch_r;
    mul_a   = cmd.mul_w ? sw_r : sh_r;
    rnd     = (PW + 1)'(prod_r) + (PW + 1)'(ROUND_HALF);
    fit_raw = RW'(rnd >> FRAC_BITS);
    fit_tgt = cmd.fit_w ? tw_r : th_r;
    if (fit_raw == '0) fit_val = TW'(1);
    else if (fit_raw > (RW > TW ? RW : TW)'(fit_tgt)) fit_val = fit_tgt;
    else fit_val = TW'(fit_raw);
  end

  // Frame setup registers
  always_ff @(posedge clk) begin
    if (cmd.hold_pix) held_px_r <= in_pixel;
    if (cmd.latch_dims) begin
      sw_r <= sw_c;
      sh_r <= sh_c;
      tw_r <= tw_f;
      th_r <= th_f;
      if (sh_c > sw_c) begin
        big_r  <= sh_c;
        half_r <= (SW - 1)'((sh_c - sw_c) >> 1);
      end else begin
        big_r  <= sw_c;
        half_r <= (SW - 1)'((sw_c - sh_c) >> 1);
      end
    end
    if (div_done) begin
      case (cmd.div_sel)
        DIV_SCALE_W: scw_r    <= SCW'(div_q);
        DIV_SCALE_H: sch_r    <= SCW'(div_q);
        DIV_STEP_X:  step_x_r <= div_q;
        DIV_STEP_Y:  step_y_r <= div_q;
        default: ;
      endcase
    end
    if (cmd.mul_w || cmd.fit_w) prod_r <= PW'(mul_a) * PW'(scale);
    if (cmd.fit_w) fw_r <= fit_val;
    if (cmd.fit_h) fh_r <= fit_val;
    if (cmd.set_pad) begin
      pad_x_r <= (TW - 1)'((tw_r - fw_r) >> 1);
      pad_y_r <= (TW - 1)'((th_r - fh_r) >> 1);
    end
  end

  // Sampler: nearest source row and column hits for the current pixel
  logic [PIXW-1:0] px;
  logic            active, row_hit, hit, row_end, last;
  logic [SW-1:0]   sy, sx;

  always_comb begin
    px      = cmd.use_held ? held_px_r : in_pixel;
    sy      = SW'(acc_y_r >> FRAC_BITS);
    sx      = SW'(acc_x_r >> FRAC_BITS);
    active  = frame_valid_r && (src_row_r < sh_r);
    row_hit = active && (dst_row_r < fh_r) && (sy == src_row_r);
    hit     = row_hit && (dst_col_r < fw_r) && (sx == src_col_r);
    row_end = ((SW + 1)'(src_col_r) + (SW + 1)'(1)) >= (SW + 1)'(sw_r);
    last    = ((TW + 1)'(dst_row_r) + (TW + 1)'(1) == (TW + 1)'(fh_r)) &&
              ((TW + 1)'(dst_col_r) + (TW + 1)'(1) == (TW + 1)'(fw_r));

    frame_valid_nxt = frame_valid_r;
    src_col_nxt     = src_col_r;
    src_row_nxt     = src_row_r;
    dst_col_nxt     = dst_col_r;
    dst_row_nxt     = dst_row_r;
    acc_x_nxt       = acc_x_r;
    acc_y_nxt       = acc_y_r;
    row_base_nxt    = row_base_r;

    if (cmd.init_frame) begin
      frame_valid_nxt = 1'b1;
      src_col_nxt     = '0;
      src_row_nxt     = '0;
      dst_col_nxt     = '0;
      dst_row_nxt     = '0;
      acc_x_nxt       = '0;
      acc_y_nxt       = '0;
      row_base_nxt    = RBW'(pad_y_r * tw_r);
    end else if (cmd.step && active) begin
      if (hit) begin
        dst_col_nxt = TW'(dst_col_r + 1'b1);
        acc_x_nxt   = DW'(acc_x_r + step_x_r);
      end
      if (row_end) begin
        src_col_nxt = '0;
        src_row_nxt = SW'(src_row_r + 1'b1);
        if (row_hit) begin
          dst_row_nxt  = TW'(dst_row_r + 1'b1);
          dst_col_nxt  = '0;
          acc_x_nxt    = '0;
          acc_y_nxt    = DW'(acc_y_r + step_y_r);
          row_base_nxt = RBW'(row_base_r + RBW'(tw_r));
        end
      end else begin
        src_col_nxt = SW'(src_col_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
      src_col_r     <= '0;
      src_row_r     <= '0;
      dst_col_r     <= '0;
      dst_row_r     <= '0;
      acc_x_r       <= '0;
      acc_y_r       <= '0;
      row_base_r    <= '0;
    end else begin
      frame_valid_r <= frame_valid_nxt;
      src_col_r     <= src_col_nxt;
      src_row_r     <= src_row_nxt;
      dst_col_r     <= dst_col_nxt;
      dst_row_r     <= dst_row_nxt;
      acc_x_r       <= acc_x_nxt;
      acc_y_r       <= acc_y_nxt;
      row_base_r    <= row_base_nxt;
    end
  end

  // Output register: loaded on a hit, cleared when taken
  logic load_out;
  assign load_out = cmd.step && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      idx_r   <= IDXW'((RBW + 1)'(row_base_r) + (RBW + 1)'(pad_x_r) + (RBW + 1)'(dst_col_r));
      red_r   <= {px[15:11], 3'b000} ^ RGB_BIAS;
      green_r <= {px[10:5], 2'b00} ^ RGB_BIAS;
      blue_r  <= {px[4:0], 3'b000} ^ RGB_BIAS;
      done_r  <= last;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.out_stall = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_dest_index  = idx_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_frame_done  = done_r;
  assign out_fit_w       = FITW'(fw_r);
  assign out_fit_h       = FITW'(fh_r);
  assign out_ofs_x       = OFSW'(pad_x_r);
  assign out_ofs_y       = OFSW'(pad_y_r);
  assign out_square      = SQW'(big_r);
  assign out_square_half = SQHW'(half_r);

endmodule

>>> rtl/core/lnr_ctrl.sv
// Controller of the resizer: accepts pixels and sequences the per-frame setup.
// Depends on lnr_pkg.
module lnr_ctrl import lnr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_frame_start,
  output logic     in_ready,
  input  lnr_sts_t sts,
  output lnr_cmd_t cmd
);

  lnr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !sts.out_stall;
        if (in_valid && !sts.out_stall) begin
          if (in_frame_start) begin
            cmd.hold_pix = 1'b1;
            state_nxt    = ST_LATCH;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_LATCH: begin
        cmd.latch_dims = 1'b1;
        state_nxt      = ST_SCW_GO;
      end
      ST_SCW_GO: begin
        cmd.div_sel   = DIV_SCALE_W;
        cmd.div_start = 1'b1;
        state_nxt     = ST_SCW_WAIT;
      end
      ST_SCW_WAIT: begin
        cmd.div_sel = DIV_SCALE_W;
        if (sts.div_done) state_nxt = ST_SCH_GO;
      end
      ST_SCH_GO: begin
        cmd.div_sel   = DIV_SCALE_H;
        cmd.div_start = 1'b1;
        state_nxt     = ST_SCH_WAIT;
      end
      ST_SCH_WAIT: begin
        cmd.div_sel = DIV_SCALE_H;
        if (sts.div_done) state_nxt = ST_MUL_W;
      end
      ST_MUL_W: begin
        cmd.mul_w = 1'b1;
        state_nxt = ST_FIT_W;
      end
      ST_FIT_W: begin
        cmd.fit_w = 1'b1;
        state_nxt = ST_FIT_H;
      end
      ST_FIT_H: begin
        cmd.fit_h = 1'b1;
        state_nxt = ST_PAD;
      end
      ST_PAD: begin
        cmd.set_pad = 1'b1;
        state_nxt   = ST_STX_GO;
      end
      ST_STX_GO: begin
        cmd.div_sel   = DIV_STEP_X;
        cmd.div_start = 1'b1;
        state_nxt     = ST_STX_WAIT;
      end
      ST_STX_WAIT: begin
        cmd.div_sel = DIV_STEP_X;
        if (sts.div_done) state_nxt = ST_STY_GO;
      end
      ST_STY_GO: begin
        cmd.div_sel   = DIV_STEP_Y;
        cmd.div_start = 1'b1;
        state_nxt     = ST_STY_WAIT;
      end
      ST_STY_WAIT: begin
        cmd.div_sel = DIV_STEP_Y;
        if (sts.div_done) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init_frame = 1'b1;
        state_nxt      = ST_PROC;
      end
      ST_PROC: begin
        // sample the held first pixel once the output slot is free
        if (!sts.out_stall) begin
          cmd.step     = 1'b1;
          cmd.use_held = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/letterbox_nearest_resize_rgb565_core.sv
// Top level of the letterbox nearest-neighbour RGB565 resizer.
// Depends on lnr_pkg, lnr_if, lnr_ctrl and lnr_datapath.
//
// Use: source pixels arrive in raster order on in_if (valid/ready); each
// request carries an RGB565 word and a frame_start flag. Sampled pixels leave
// on out_if with the destination index, signed 8-bit channels and the frame's
// letterbox figures. The four dimension registers sit on the APB port at
// byte addresses 0, 4, 8 and 12 and take effect at the next frame start.
// Flow: an ordinary pixel is accepted every cycle while the output register
// is not stalled, and its result, if any, sits in the output register in the
// cycle after. A pixel with frame_start set holds the input off during frame
// setup: latch the dimensions, run four divisions in the one shift-subtract
// divider, fit, pad, clear the counters and sample the held pixel, whose
// result then sits in the register. Reset: the registers return to 640x480
// -> 192x192, counters clear, and no result is given until the first frame
// start. A stalled receiver holds the output register; input is accepted
// again as soon as it is taken.
module letterbox_nearest_resize_rgb565_core import lnr_pkg::*; #(
  parameter int MAX_SOURCE_DIM = DEF_MAX_SOURCE_DIM,
  parameter int MAX_TARGET_DIM = DEF_MAX_TARGET_DIM
) (
  input  logic              clk,
  input  logic              rst_n,
  lnr_pix_if.sink           in_if,
  lnr_res_if.source         out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [SRCRW-1:0] src_w_r, src_h_r;
  logic [TGTRW-1:0] tgt_w_r, tgt_h_r;
  lnr_cfg_reg_t     cfg_sel;
  lnr_cmd_t         cmd;
  lnr_sts_t         sts;
  logic             in_ready;

  // Register file
  assign cfg_sel    = lnr_cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SRC_W;
      src_h_r <= RST_SRC_H;
      tgt_w_r <= RST_TGT_W;
      tgt_h_r <= RST_TGT_H;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_sel)
        CFG_SRC_W: src_w_r <= cfg_pwdata[SRCRW-1:0];
        CFG_SRC_H: src_h_r <= cfg_pwdata[SRCRW-1:0];
        CFG_TGT_W: tgt_w_r <= cfg_pwdata[TGTRW-1:0];
        CFG_TGT_H: tgt_h_r <= cfg_pwdata[TGTRW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      CFG_SRC_W: cfg_prdata = CFG_DW'(src_w_r);
      CFG_SRC_H: cfg_prdata = CFG_DW'(src_h_r);
      CFG_TGT_W: cfg_prdata = CFG_DW'(tgt_w_r);
      CFG_TGT_H: cfg_prdata = CFG_DW'(tgt_h_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // Controller
  lnr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_frame_start (in_if.frame_start),
    .in_ready       (in_ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  assign in_if.ready = in_ready;

  // Datapath
  lnr_datapath #(
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM),
    .MAX_TARGET_DIM(MAX_TARGET_DIM)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_src_w       (src_w_r),
    .cfg_src_h       (src_h_r),
    .cfg_tgt_w       (tgt_w_r),
    .cfg_tgt_h       (tgt_h_r),
    .in_pixel        (in_if.pixel_word),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_dest_index  (out_if.dest_index),
    .out_red         (out_if.red_value),
    .out_green       (out_if.green_value),
    .out_blue        (out_if.blue_value),
    .out_frame_done  (out_if.frame_done),
    .out_fit_w       (out_if.fitted_width),
    .out_fit_h       (out_if.fitted_height),
    .out_ofs_x       (out_if.offset_x),
    .out_ofs_y       (out_if.offset_y),
    .out_square      (out_if.square_size),
    .out_square_half (out_if.square_pad_half)
  );

endmodule
